// File: src/pointer_position_tracker_macros.svh
// Assertion macros for the pointer position tracker.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef POINTER_POSITION_TRACKER_MACROS_SVH
`define POINTER_POSITION_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define PPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PPT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PPT_ASSERT(lbl, prop, msg)
`define PPT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/ppt_pkg.sv
// Shared types and constants of the pointer position tracker.
// No dependencies; imported by every module of the block.
package ppt_pkg;

	localparam int DEF_REF_WIDTH = 640;
	localparam int DEF_REF_HEIGHT = 480;
	localparam int DEF_COUNTS_PER_PIXEL = 2;

	localparam int VALUE_W = 32;
	localparam int CANVAS_W = 10;
	localparam int HEIGHT_W = 9;
	localparam int REF_POS_W = 15;
	localparam int REF_SUM_W = REF_POS_W + 3;
	localparam int DELTA_W = 16;
	localparam int QUO_REL_W = DELTA_W + 1;
	localparam int FLAG_W = 8;
	localparam int BUTTON_W = 5;
	localparam int WIN_W = 8;
	localparam int COUNT_W = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int IN_DATA_W = 88;
	localparam int OUT_DATA_W = 64;

	// Shared multiplier and divider widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 13;
	localparam int DIV_NUM_W = 42;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = 6;

	// Quotient bits per division kind
	localparam logic [DIV_CNT_W-1:0] DIV_COUNT_FRAC = DIV_CNT_W'(DELTA_W);
	localparam logic [DIV_CNT_W-1:0] DIV_COUNT_SMALL = DIV_CNT_W'(22);
	localparam logic [DIV_CNT_W-1:0] DIV_COUNT_WIDE = DIV_CNT_W'(DIV_NUM_W);

	// Window boundaries of the position encoding
	localparam logic [CANVAS_W-1:0] WIN_LOW_LAST = CANVAS_W'(254);
	localparam logic [CANVAS_W-1:0] WIN_MID_LAST = CANVAS_W'(509);
	localparam logic [CANVAS_W-1:0] WIN_HIGH_LAST = CANVAS_W'(764);

	localparam logic [CANVAS_W-1:0] RST_CANVAS_WIDTH = CANVAS_W'(640);
	localparam logic [HEIGHT_W-1:0] RST_CANVAS_HEIGHT = HEIGHT_W'(480);

	localparam int FLAG_HOVER_BIT = 7;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CANVAS_WIDTH  = 3'd0,
		CFG_CANVAS_HEIGHT = 3'd1,
		CFG_RELATIVE_MODE = 3'd2,
		CFG_X_LOWER       = 3'd3,
		CFG_X_UPPER       = 3'd4,
		CFG_Y_LOWER       = 3'd5,
		CFG_Y_UPPER       = 3'd6,
		CFG_HAS_IN_RANGE  = 3'd7
	} cfg_index_t;

	// Effective configuration: zero canvas sizes already replaced by one
	typedef struct packed {
		logic [CANVAS_W-1:0] width;
		logic [HEIGHT_W-1:0] height;
		logic                relative;
		logic                has_in_range;
		logic [VALUE_W-1:0]  x_lower;
		logic [VALUE_W-1:0]  x_upper;
		logic [VALUE_W-1:0]  y_lower;
		logic [VALUE_W-1:0]  y_upper;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] count;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
		logic [DIV_DEN_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SETUP,
		SEQ_DIVIDE,
		SEQ_DELIVER
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_FRAC_X,
		OP_FRAC_Y,
		OP_CANVAS_X,
		OP_CANVAS_Y,
		OP_RESYNC_X,
		OP_RESYNC_Y
	} op_t;

endpackage

// File: src/ppt_div.sv
// Shared restoring divider of the pointer position tracker, one quotient bit per cycle.
// Depends on ppt_pkg for the request and response structs.
module ppt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ppt_pkg::div_req_t req,
	output ppt_pkg::div_rsp_t rsp
);
	import ppt_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W+1:0] trial;

	assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.count;
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Left-align the dividend so that exactly count steps consume it
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend << (DIV_CNT_W'(DIV_NUM_W) - req.count);
		end else if (run_q) begin
			if (trial[DIV_DEN_W+1]) begin
				rem_q <= rem_sh[DIV_DEN_W-1:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DIV_DEN_W-1:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: src/ppt_seq.sv
// Sequencer and position state of the pointer position tracker.
// Depends on ppt_pkg; drives the shared multiplier and the ppt_div divider.
module ppt_seq #(
	parameter int REF_WIDTH = ppt_pkg::DEF_REF_WIDTH,
	parameter int REF_HEIGHT = ppt_pkg::DEF_REF_HEIGHT,
	parameter int COUNTS_PER_PIXEL = ppt_pkg::DEF_COUNTS_PER_PIXEL
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ppt_pkg::VALUE_W-1:0] x_value,
	input  logic signed [ppt_pkg::VALUE_W-1:0] y_value,
	input  ppt_pkg::cfg_t                      cfg,
	input  logic                               out_free,
	output logic                               ready,
	output logic                               done,
	output logic [ppt_pkg::CANVAS_W-1:0]       canvas_x,
	output logic [ppt_pkg::CANVAS_W-1:0]       canvas_y,
	output ppt_pkg::div_req_t                  div_req,
	input  ppt_pkg::div_rsp_t                  div_rsp
);
	import ppt_pkg::*;

	localparam int FRAC_W = $clog2(COUNTS_PER_PIXEL) + 1;
	localparam logic [REF_POS_W-1:0] REF_X_LIM = REF_POS_W'(REF_WIDTH - 1);
	localparam logic [REF_POS_W-1:0] REF_Y_LIM = REF_POS_W'(REF_HEIGHT - 1);
	localparam logic [MUL_B_W-1:0] REF_WIDTH_B = MUL_B_W'(REF_WIDTH);

	seq_state_t state_q, state_d;
	op_t        op_q, op_d, op_succ;
	logic       op_last;

	logic signed [VALUE_W-1:0] x_q, y_q;
	logic signed [FRAC_W-1:0]  frac_x_q, frac_y_q;
	logic [REF_POS_W-1:0]      ref_x_q, ref_y_q;
	logic [CANVAS_W-1:0]       canvas_x_q, canvas_y_q;
	logic                      sign_q;

	logic                      is_y;
	logic [VALUE_W-1:0]        raw, lower, upper;
	logic signed [FRAC_W-1:0]  frac_cur;
	logic [REF_POS_W-1:0]      ref_cur, ref_lim;
	logic [CANVAS_W-1:0]       canvas_cur, size_m1;
	logic [VALUE_W:0]          span, diff;
	logic                      span_pos;
	logic [DELTA_W-1:0]        sum16;
	logic [DELTA_W:0]          mag;

	logic [MUL_A_W-1:0]         mul_a;
	logic [MUL_B_W-1:0]         mul_b;
	logic [MUL_A_W+MUL_B_W-1:0] product;
	logic                       use_mul;
	logic [DELTA_W-1:0]         frac_dividend;

	logic [QUO_REL_W-1:0]        quo_rel;
	logic signed [REF_SUM_W-1:0] ref_sum;
	logic [FRAC_W-1:0]           rem_low;

	logic                      load_item, load_sign;
	logic                      wr_ref, wr_frac, wr_canvas;
	logic [REF_POS_W-1:0]      ref_new;
	logic signed [FRAC_W-1:0]  frac_new;
	logic [CANVAS_W-1:0]       canvas_new;

	// Operand selection for the current step
	always_comb begin
		is_y = (op_q == OP_FRAC_Y) || (op_q == OP_CANVAS_Y) || (op_q == OP_RESYNC_Y);
		raw = is_y ? y_q : x_q;
		lower = is_y ? cfg.y_lower : cfg.x_lower;
		upper = is_y ? cfg.y_upper : cfg.x_upper;
		frac_cur = is_y ? frac_y_q : frac_x_q;
		ref_cur = is_y ? ref_y_q : ref_x_q;
		ref_lim = is_y ? REF_Y_LIM : REF_X_LIM;
		canvas_cur = is_y ? canvas_y_q : canvas_x_q;
		size_m1 = (is_y ? CANVAS_W'(cfg.height) : cfg.width) - CANVAS_W'(1);
		span = {upper[VALUE_W-1], upper} - {lower[VALUE_W-1], lower};
		diff = {raw[VALUE_W-1], raw} - {lower[VALUE_W-1], lower};
		span_pos = !span[VALUE_W] && (span != '0);
		sum16 = {{(DELTA_W-FRAC_W){frac_cur[FRAC_W-1]}}, frac_cur} + raw[DELTA_W-1:0];
		mag = sum16[DELTA_W-1] ? ((DELTA_W+1)'(0) - {1'b1, sum16}) : {1'b0, sum16};
		frac_dividend = mag[DELTA_W-1:0];
	end

	// Step successor: relative items run fractions then canvas, absolute ones canvas then resync
	always_comb begin
		op_succ = op_q;
		op_last = 1'b0;
		case (op_q)
			OP_FRAC_X: op_succ = OP_FRAC_Y;
			OP_FRAC_Y: op_succ = OP_CANVAS_X;
			OP_CANVAS_X: op_succ = OP_CANVAS_Y;
			OP_CANVAS_Y: begin
				op_succ = OP_RESYNC_X;
				op_last = cfg.relative;
			end
			OP_RESYNC_X: op_succ = OP_RESYNC_Y;
			default: op_last = 1'b1;
		endcase
	end

	// Writeback values from the divider result
	always_comb begin
		quo_rel = sign_q ? (QUO_REL_W'(0) - div_rsp.quotient[QUO_REL_W-1:0])
			: div_rsp.quotient[QUO_REL_W-1:0];
		ref_sum = $signed({3'b000, ref_cur}) + $signed({quo_rel[QUO_REL_W-1], quo_rel});
		rem_low = div_rsp.remainder[FRAC_W-1:0];
	end

	assign product = mul_a * mul_b;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		ready = 1'b0;
		done = 1'b0;
		load_item = 1'b0;
		load_sign = 1'b0;
		use_mul = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_req.start = 1'b0;
		div_req.count = DIV_COUNT_SMALL;
		div_req.divisor = DIV_DEN_W'(cfg.width);
		wr_ref = 1'b0;
		wr_frac = 1'b0;
		wr_canvas = 1'b0;
		ref_new = ref_cur;
		frac_new = '0;
		canvas_new = canvas_cur;
		unique case (state_q)
			SEQ_IDLE: begin
				ready = 1'b1;
				if (start) begin
					load_item = 1'b1;
					op_d = cfg.relative ? OP_FRAC_X : OP_CANVAS_X;
					state_d = SEQ_SETUP;
				end
			end
			SEQ_SETUP: begin
				state_d = SEQ_DIVIDE;
				case (op_q) inside
					OP_FRAC_X, OP_FRAC_Y: begin
						load_sign = 1'b1;
						div_req.start = 1'b1;
						div_req.count = DIV_COUNT_FRAC;
						div_req.divisor = DIV_DEN_W'(COUNTS_PER_PIXEL);
					end
					OP_CANVAS_X, OP_CANVAS_Y: begin
						if (cfg.relative) begin
							use_mul = 1'b1;
							mul_a = MUL_A_W'(ref_cur);
							mul_b = MUL_B_W'(cfg.width);
							div_req.start = 1'b1;
							div_req.divisor = DIV_DEN_W'(REF_WIDTH);
						end else if (!span_pos) begin
							// Degenerate axis: keep the old position, clamped
							wr_canvas = 1'b1;
							canvas_new = (canvas_cur > size_m1) ? size_m1 : canvas_cur;
						end else if (diff[VALUE_W]) begin
							// Below the lower bound: the quotient saturates at zero
							wr_canvas = 1'b1;
							canvas_new = '0;
						end else begin
							use_mul = 1'b1;
							mul_a = diff[VALUE_W-1:0];
							mul_b = MUL_B_W'(size_m1);
							div_req.start = 1'b1;
							div_req.count = DIV_COUNT_WIDE;
							div_req.divisor = span[DIV_DEN_W-1:0];
						end
					end
					default: begin
						use_mul = 1'b1;
						mul_a = MUL_A_W'(canvas_cur);
						mul_b = REF_WIDTH_B;
						div_req.start = 1'b1;
					end
				endcase
				if (!div_req.start) begin
					op_d = op_succ;
					state_d = op_last ? SEQ_DELIVER : SEQ_SETUP;
				end
			end
			SEQ_DIVIDE: begin
				if (div_rsp.done) begin
					op_d = op_succ;
					state_d = op_last ? SEQ_DELIVER : SEQ_SETUP;
					case (op_q) inside
						OP_FRAC_X, OP_FRAC_Y: begin
							wr_ref = 1'b1;
							wr_frac = 1'b1;
							frac_new = sign_q ? (FRAC_W'(0) - rem_low) : rem_low;
							if (ref_sum < 0) begin
								ref_new = '0;
							end else if (ref_sum > $signed({3'b000, ref_lim})) begin
								ref_new = ref_lim;
							end else begin
								ref_new = ref_sum[REF_POS_W-1:0];
							end
						end
						OP_CANVAS_X, OP_CANVAS_Y: begin
							wr_canvas = 1'b1;
							canvas_new = (div_rsp.quotient > DIV_NUM_W'(size_m1)) ? size_m1
								: div_rsp.quotient[CANVAS_W-1:0];
						end
						default: begin
							wr_ref = 1'b1;
							wr_frac = 1'b1;
							frac_new = '0;
							ref_new = (|div_rsp.quotient[DIV_NUM_W-1:REF_POS_W]) ? '1
								: div_rsp.quotient[REF_POS_W-1:0];
						end
					endcase
				end
			end
			SEQ_DELIVER: begin
				if (out_free) begin
					done = 1'b1;
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
		div_req.dividend = use_mul ? product[DIV_NUM_W-1:0] : DIV_NUM_W'(frac_dividend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			op_q <= OP_FRAC_X;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			ref_x_q <= '0;
			ref_y_q <= '0;
			canvas_x_q <= '0;
			canvas_y_q <= '0;
		end else begin
			if (wr_frac) begin
				if (is_y) frac_y_q <= frac_new;
				else frac_x_q <= frac_new;
			end
			if (wr_ref) begin
				if (is_y) ref_y_q <= ref_new;
				else ref_x_q <= ref_new;
			end
			if (wr_canvas) begin
				if (is_y) canvas_y_q <= canvas_new;
				else canvas_x_q <= canvas_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			x_q <= x_value;
			y_q <= y_value;
		end
		if (load_sign) begin
			sign_q <= sum16[DELTA_W-1];
		end
	end

	assign canvas_x = canvas_x_q;
	assign canvas_y = canvas_y_q;

endmodule

// File: src/pointer_position_tracker.sv
// Pointer position tracker top level: configuration registers, stream ports, result encoding.
// Depends on ppt_pkg, ppt_div, ppt_seq and pointer_position_tracker_macros.svh.
//
// Usage: one pointer report is a transfer on the s_ group; one result follows on the m_ group.
// Configuration registers are written over cfg_we/cfg_index/cfg_wdata; the user must write them
// only while the block is idle, since the block itself does not enforce this. Each report
// runs through a sequencer that reuses one multiplier and one restoring divider (one
// quotient bit per cycle). A relative item runs two fraction and two canvas divisions, an
// absolute item two canvas and two resync divisions; a degenerate or below-range axis skips
// its canvas division. s_tready is low for the whole item.
// Results land in an output register, so s_tready rises again while a result waits on m_tready.
// When the receiver stalls, a finished item holds in the sequencer until the output register
// frees; nothing is dropped or overwritten.
// Reset clears the configuration to its defaults (640 x 480 canvas, relative mode), the
// position, fraction and counter state, and empties the output register.
`include "pointer_position_tracker_macros.svh"

module pointer_position_tracker #(
	parameter int REF_WIDTH = ppt_pkg::DEF_REF_WIDTH,
	parameter int REF_HEIGHT = ppt_pkg::DEF_REF_HEIGHT,
	parameter int COUNTS_PER_PIXEL = ppt_pkg::DEF_COUNTS_PER_PIXEL
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata, lowest bit up: x_value[31:0], y_value[31:0], button_bits[4:0], tip_down,
	// in_range, wheel_delta[7:0], pan_delta[7:0], one zero pad bit
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ppt_pkg::IN_DATA_W-1:0]       s_tdata,
	// m_tdata, lowest bit up: contact_flags, x_window_low, x_window_mid, x_window_high,
	// y_window_low, y_window_high, wheel_count, pan_count, eight bits each
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ppt_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [ppt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import ppt_pkg::*;

	// Configuration registers
	logic [CANVAS_W-1:0] canvas_width_q;
	logic [HEIGHT_W-1:0] canvas_height_q;
	logic                relative_mode_q;
	logic [VALUE_W-1:0]  x_lower_q, x_upper_q, y_lower_q, y_upper_q;
	logic                has_in_range_q;
	cfg_t                cfg_eff;

	// Report fields held for the result
	logic [BUTTON_W-1:0] buttons_q;
	logic                tip_q;
	logic                in_range_q;
	logic [COUNT_W-1:0]  wheel_delta_q, pan_delta_q;

	// Running counters and output register
	logic [COUNT_W-1:0]    wheel_total_q, pan_total_q;
	logic [COUNT_W-1:0]    wheel_next, pan_next;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic                  in_xfer, out_free;
	logic                  core_ready, core_done;
	logic [CANVAS_W-1:0]   canvas_x, canvas_y;
	logic [CANVAS_W-1:0]   x_clip, y_clip;
	logic [FLAG_W-1:0]     flags;
	logic                  hover;
	logic [WIN_W-1:0]      x_win_low, x_win_mid, x_win_high, y_win_low, y_win_high;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	assign in_xfer = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = core_ready;

	// Register writes; a zero canvas size acts as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q <= RST_CANVAS_WIDTH;
			canvas_height_q <= RST_CANVAS_HEIGHT;
			relative_mode_q <= 1'b1;
			x_lower_q <= '0;
			x_upper_q <= '0;
			y_lower_q <= '0;
			y_upper_q <= '0;
			has_in_range_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CANVAS_WIDTH: canvas_width_q <= cfg_wdata[CANVAS_W-1:0];
				CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_wdata[HEIGHT_W-1:0];
				CFG_RELATIVE_MODE: relative_mode_q <= cfg_wdata[0];
				CFG_X_LOWER: x_lower_q <= cfg_wdata[VALUE_W-1:0];
				CFG_X_UPPER: x_upper_q <= cfg_wdata[VALUE_W-1:0];
				CFG_Y_LOWER: y_lower_q <= cfg_wdata[VALUE_W-1:0];
				CFG_Y_UPPER: y_upper_q <= cfg_wdata[VALUE_W-1:0];
				CFG_HAS_IN_RANGE: has_in_range_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_eff.width = (canvas_width_q == '0) ? CANVAS_W'(1) : canvas_width_q;
		cfg_eff.height = (canvas_height_q == '0) ? HEIGHT_W'(1) : canvas_height_q;
		cfg_eff.relative = relative_mode_q;
		cfg_eff.has_in_range = has_in_range_q;
		cfg_eff.x_lower = x_lower_q;
		cfg_eff.x_upper = x_upper_q;
		cfg_eff.y_lower = y_lower_q;
		cfg_eff.y_upper = y_upper_q;
	end

	// Capture the side fields of a report on its transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			buttons_q <= s_tdata[68:64];
			tip_q <= s_tdata[69];
			in_range_q <= s_tdata[70];
			wheel_delta_q <= s_tdata[78:71];
			pan_delta_q <= s_tdata[86:79];
		end
	end

	ppt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ppt_seq #(
		.REF_WIDTH        (REF_WIDTH),
		.REF_HEIGHT       (REF_HEIGHT),
		.COUNTS_PER_PIXEL (COUNTS_PER_PIXEL)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.x_value  (s_tdata[31:0]),
		.y_value  (s_tdata[63:32]),
		.cfg      (cfg_eff),
		.out_free (out_free),
		.ready    (core_ready),
		.done     (core_done),
		.canvas_x (canvas_x),
		.canvas_y (canvas_y),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	// Result encoding: hover is forced in relative mode, else taken from the pen
	// when the device reports it; positions are split into byte-sized windows
	always_comb begin
		hover = relative_mode_q || (has_in_range_q && in_range_q);
		flags = {hover, 2'b00, buttons_q[BUTTON_W-1:1], buttons_q[0] | tip_q};
		wheel_next = wheel_total_q + wheel_delta_q;
		pan_next = pan_total_q + pan_delta_q;
		x_clip = (canvas_x > WIN_HIGH_LAST) ? WIN_HIGH_LAST : canvas_x;
		y_clip = (canvas_y > WIN_MID_LAST) ? WIN_MID_LAST : canvas_y;
		x_win_low = (x_clip <= WIN_LOW_LAST) ? WIN_W'(x_clip + CANVAS_W'(1)) : '0;
		x_win_mid = (x_clip > WIN_LOW_LAST && x_clip <= WIN_MID_LAST)
			? WIN_W'(x_clip - WIN_LOW_LAST) : '0;
		x_win_high = (x_clip > WIN_MID_LAST) ? WIN_W'(x_clip - WIN_MID_LAST) : '0;
		y_win_low = (y_clip <= WIN_LOW_LAST) ? WIN_W'(y_clip + CANVAS_W'(1)) : '0;
		y_win_high = (y_clip > WIN_LOW_LAST) ? WIN_W'(y_clip - WIN_LOW_LAST) : '0;
	end

	// Advance the counters and load the output register when the item completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_total_q <= '0;
			pan_total_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (core_done) begin
				wheel_total_q <= wheel_next;
				pan_total_q <= pan_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			m_tdata_q <= {pan_next, wheel_next, y_win_high, y_win_low,
				x_win_high, x_win_mid, x_win_low, flags};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// A finished item must never overwrite a result that is still waiting
	`PPT_ASSERT(a_no_overwrite, core_done |-> (!m_tvalid_q || m_tready), "result overwritten")
	// An accepted report keeps the block busy for at least the next cycle
	`PPT_ASSERT(a_busy_after_xfer, in_xfer |=> !s_tready, "ready right after a transfer")
	// Delivered positions lie on the canvas
	`PPT_ASSERT(a_on_canvas, core_done |-> (canvas_x < cfg_eff.width && canvas_y < CANVAS_W'(cfg_eff.height)), "position off canvas")
	// The output register fills only from a completed item
	`PPT_ASSERT(a_valid_source, $rose(m_tvalid_q) |-> $past(core_done), "output valid without a result")

endmodule

// File: sim/pointer_position_tracker_tb.sv
// Self-checking testbench for pointer_position_tracker: directed and random pointer reports
// against a cycle-free predictor of positions, windows and counters. Depends on ppt_pkg and
// the block's RTL only.
module pointer_position_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppt_pkg::*;

	localparam int REF_W = DEF_REF_WIDTH;
	localparam int REF_H = DEF_REF_HEIGHT;
	localparam int CPP = DEF_COUNTS_PER_PIXEL;
	localparam int REF_SAT = (1 << REF_POS_W) - 1;
	localparam int X_LOW_LAST = WIN_LOW_LAST;
	localparam int X_MID_LAST = WIN_MID_LAST;
	localparam int X_HIGH_LAST = WIN_HIGH_LAST;
	// Cycles without any transfer or register write before the run is declared hung
	localparam int QUIET_LIMIT = 3000;

	// One pointer report, laid out exactly as s_tdata (first field lowest)
	typedef struct packed {
		logic        pad;
		logic [7:0]  pan_delta;
		logic [7:0]  wheel_delta;
		logic        in_range;
		logic        tip_down;
		logic [4:0]  button_bits;
		logic [31:0] y_value;
		logic [31:0] x_value;
	} pointer_report_t;

	// One result, laid out exactly as m_tdata
	typedef struct packed {
		logic [7:0] pan_count;
		logic [7:0] wheel_count;
		logic [7:0] y_window_high;
		logic [7:0] y_window_low;
		logic [7:0] x_window_high;
		logic [7:0] x_window_mid;
		logic [7:0] x_window_low;
		logic [7:0] contact_flags;
	} pointer_result_t;

	string result_field_names [8] = '{"contact_flags", "x_window_low", "x_window_mid",
		"x_window_high", "y_window_low", "y_window_high", "wheel_count", "pan_count"};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_CANVAS_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	pointer_position_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the configuration, at reset values
	logic [CANVAS_W-1:0] cfg_width = RST_CANVAS_WIDTH;
	logic [HEIGHT_W-1:0] cfg_height = RST_CANVAS_HEIGHT;
	logic                cfg_relative = 1'b1;
	int                  cfg_x_lower = 0;
	int                  cfg_x_upper = 0;
	int                  cfg_y_lower = 0;
	int                  cfg_y_upper = 0;
	logic                cfg_in_range_en = 1'b0;

	// Predictor copy of the tracking state, all zero at reset
	int         pos_ref_x = 0;
	int         pos_ref_y = 0;
	int         frac_acc_x = 0;
	int         frac_acc_y = 0;
	int         canvas_x = 0;
	int         canvas_y = 0;
	logic [7:0] wheel_sum = '0;
	logic [7:0] pan_sum = '0;

	pointer_result_t expected_results [$];
	int unsigned     mismatches = 0;
	int unsigned     quiet_cycles = 0;
	int unsigned     stall_left = 0;
	bit              no_stall = 1'b0;

	function automatic longint bound(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Add a 16-bit delta into the sub-count accumulator (wrapping at 16 bits), move the
	// reference coordinate by the truncated quotient and keep the remainder.
	function automatic void advance_axis(inout int frac, inout int pos, input logic [15:0] delta,
		input int span);
		logic signed [15:0] wrapped;
		int quo;
		wrapped = 16'(frac + int'($signed(delta)));
		quo = int'(wrapped) / CPP;
		frac = int'(wrapped) - quo * CPP;
		pos = int'(bound(longint'(pos) + quo, 0, span - 1));
	endfunction

	// Map a raw absolute value from lower..upper onto 0..size-1; a span that is not
	// positive keeps the old position.
	function automatic int map_axis(input logic [31:0] raw, input int lower, input int upper,
		input longint size, input int old);
		longint span;
		longint scaled;
		span = longint'(upper) - longint'(lower);
		if (span <= 0)
			return old;
		scaled = (longint'($signed(raw)) - longint'(lower)) * (size - 1) / span;
		return int'(bound(scaled, 0, size - 1));
	endfunction

	// Advance the tracking state by one report and encode the result it produces.
	function automatic pointer_result_t track_report(input pointer_report_t r);
		pointer_result_t res;
		longint cw;
		longint ch;
		int win_x;
		int win_y;
		logic hover;
		cw = (cfg_width == 0) ? 1 : cfg_width;
		ch = (cfg_height == 0) ? 1 : cfg_height;
		if (cfg_relative) begin
			advance_axis(frac_acc_x, pos_ref_x, r.x_value[15:0], REF_W);
			advance_axis(frac_acc_y, pos_ref_y, r.y_value[15:0], REF_H);
			// Y uses the width ratio as well
			canvas_x = int'(longint'(pos_ref_x) * cw / REF_W);
			canvas_y = int'(longint'(pos_ref_y) * cw / REF_W);
			hover = 1'b1;
		end else begin
			canvas_x = map_axis(r.x_value, cfg_x_lower, cfg_x_upper, cw, canvas_x);
			canvas_y = map_axis(r.y_value, cfg_y_lower, cfg_y_upper, ch, canvas_y);
			hover = cfg_in_range_en & r.in_range;
		end
		canvas_x = int'(bound(canvas_x, 0, cw - 1));
		canvas_y = int'(bound(canvas_y, 0, ch - 1));
		if (!cfg_relative) begin
			// Resync the reference from the canvas and drop pending sub-counts
			pos_ref_x = int'(bound(longint'(canvas_x) * REF_W / cw, 0, REF_SAT));
			pos_ref_y = int'(bound(longint'(canvas_y) * REF_W / cw, 0, REF_SAT));
			frac_acc_x = 0;
			frac_acc_y = 0;
		end
		wheel_sum = wheel_sum + r.wheel_delta;
		pan_sum = pan_sum + r.pan_delta;
		win_x = int'(bound(canvas_x, 0, X_HIGH_LAST));
		win_y = int'(bound(canvas_y, 0, X_MID_LAST));
		res.contact_flags = {hover, 2'b00, r.button_bits | {4'b0000, r.tip_down}};
		res.x_window_low = (win_x <= X_LOW_LAST) ? 8'(win_x + 1) : 8'd0;
		res.x_window_mid = (win_x > X_LOW_LAST && win_x <= X_MID_LAST) ?
			8'(win_x - X_LOW_LAST) : 8'd0;
		res.x_window_high = (win_x > X_MID_LAST) ? 8'(win_x - X_MID_LAST) : 8'd0;
		res.y_window_low = (win_y <= X_LOW_LAST) ? 8'(win_y + 1) : 8'd0;
		res.y_window_high = (win_y > X_LOW_LAST) ? 8'(win_y - X_LOW_LAST) : 8'd0;
		res.wheel_count = wheel_sum;
		res.pan_count = pan_sum;
		return res;
	endfunction

	function automatic pointer_report_t make_report(input logic [31:0] x, input logic [31:0] y,
		input logic [4:0] buttons, input logic tip, input logic in_range, input logic [7:0] wheel,
		input logic [7:0] pan);
		pointer_report_t r;
		r.pad = 1'b0;
		r.x_value = x;
		r.y_value = y;
		r.button_bits = buttons;
		r.tip_down = tip;
		r.in_range = in_range;
		r.wheel_delta = wheel;
		r.pan_delta = pan;
		return r;
	endfunction

	// Mostly small mouse motion, some sweeps, the extremes and raw noise
	function automatic logic [15:0] random_delta();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom_range(0, 16)) - 16'd8;
			5, 6: return 16'($urandom_range(0, 800)) - 16'd400;
			7: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly values inside the declared range, plus its ends and strays outside it
	function automatic logic [31:0] random_raw(input int lower, input int upper);
		longint span;
		span = longint'(upper) - longint'(lower);
		case ($urandom_range(0, 9))
			0: return lower;
			1: return upper;
			2: return $urandom;
			3: return 32'(longint'(lower) - $urandom_range(1, 50));
			4: return 32'(longint'(upper) + $urandom_range(1, 50));
			default: begin
				if (span > 0)
					return 32'(longint'(lower) + longint'($urandom) % (span + 1));
				else
					return $urandom;
			end
		endcase
	endfunction

	function automatic pointer_report_t random_report();
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0] wheel;
		logic [7:0] pan;
		x = $urandom;
		y = $urandom;
		if (cfg_relative) begin
			// upper halves stay random: the block must ignore them
			x[15:0] = random_delta();
			y[15:0] = random_delta();
		end else begin
			x = random_raw(cfg_x_lower, cfg_x_upper);
			y = random_raw(cfg_y_lower, cfg_y_upper);
		end
		wheel = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		pan = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		return make_report(x, y, 5'($urandom), 1'($urandom), 1'($urandom), wheel, pan);
	endfunction

	function automatic void random_span(output int lower, output int upper);
		int t;
		case ($urandom_range(0, 6))
			0: begin
				lower = 0;
				upper = 4095;
			end
			1: begin
				lower = -32768;
				upper = 32767;
			end
			2: begin
				lower = 32'h8000_0000;
				upper = 32'h7FFF_FFFF;
			end
			3: begin
				// zero span: the axis holds its position
				lower = $urandom;
				upper = lower;
			end
			4: begin
				// reversed range: the axis holds its position
				upper = $urandom_range(0, 1000);
				lower = upper + int'($urandom_range(1, 1000));
			end
			default: begin
				lower = $urandom;
				upper = $urandom;
				if (lower > upper) begin
					t = lower;
					lower = upper;
					upper = t;
				end
			end
		endcase
	endfunction

	// Write one register once the block has drained; mirror it in the predictor.
	task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CANVAS_WIDTH: cfg_width = value[CANVAS_W-1:0];
			CFG_CANVAS_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
			CFG_RELATIVE_MODE: cfg_relative = value[0];
			CFG_X_LOWER: cfg_x_lower = value;
			CFG_X_UPPER: cfg_x_upper = value;
			CFG_Y_LOWER: cfg_y_lower = value;
			CFG_Y_UPPER: cfg_y_upper = value;
			CFG_HAS_IN_RANGE: cfg_in_range_en = value[0];
			default: ;
		endcase
	endtask

	// Offer one report, wait for its transfer and queue the predicted result. A random gap
	// goes either right after the previous transfer or after the block shows ready again.
	task automatic send_report(input pointer_report_t r);
		int unsigned gap;
		gap = 0;
		if (!no_stall && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			if ($urandom_range(0, 1))
				do @(posedge clk); while (!s_tready);
		end
		repeat (gap) @(negedge clk);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= r;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(track_report(r));
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic apply_random_setup(input bit relative);
		int xl;
		int xu;
		int yl;
		int yu;
		logic [CANVAS_W-1:0] w;
		logic [HEIGHT_W-1:0] h;
		case ($urandom_range(0, 7))
			0: w = 10'd0;
			1: w = 10'd1;
			2: w = 10'd765;
			3: w = 10'd1023;
			4: w = RST_CANVAS_WIDTH;
			default: w = 10'($urandom_range(1, 765));
		endcase
		case ($urandom_range(0, 7))
			0: h = 9'd0;
			1: h = 9'd1;
			2: h = 9'd510;
			3: h = 9'd511;
			4: h = RST_CANVAS_HEIGHT;
			default: h = 9'($urandom_range(1, 510));
		endcase
		random_span(xl, xu);
		random_span(yl, yu);
		write_register(CFG_CANVAS_WIDTH, 32'(w));
		write_register(CFG_CANVAS_HEIGHT, 32'(h));
		write_register(CFG_RELATIVE_MODE, 32'(relative));
		write_register(CFG_X_LOWER, xl);
		write_register(CFG_X_UPPER, xu);
		write_register(CFG_Y_LOWER, yl);
		write_register(CFG_Y_UPPER, yu);
		write_register(CFG_HAS_IN_RANGE, 32'($urandom_range(0, 1)));
	endtask

	// Alternate relative and absolute settings, a fresh random setup per phase.
	task automatic run_phases(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			apply_random_setup(p % 2 == 0);
			repeat (per_phase) send_report(random_report());
		end
	endtask

	// Reset configuration: relative mode on a 640 x 480 canvas. Walk through sub-count
	// carry, accumulator wrap, reference clamping at both ends and the flag/counter extremes.
	task automatic test_relative_reset_state();
		send_report(make_report(32'd0, 32'd0, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		// leave +1 and -1 pending in the accumulators
		send_report(make_report(32'd1, 32'hFFFF_FFFF, 5'h01, 1'b0, 1'b1, 8'h01, 8'hFF));
		// both accumulators wrap at 16 bits; reference clamps low on X, high on Y
		send_report(make_report(32'h0000_7FFF, 32'hFFFF_8000, 5'h02, 1'b0, 1'b0, 8'h00, 8'h00));
		send_report(make_report(32'd1, 32'd1, 5'h04, 1'b1, 1'b0, 8'h10, 8'hF0));
		send_report(make_report(32'hFFFF_7FFF, 32'h0000_8000, 5'h1F, 1'b1, 1'b1, 8'h7F, 8'h80));
		// upper halves carry garbage that must be ignored
		send_report(make_report(32'h1234_0000, 32'hABCD_0003, 5'h0A, 1'b1, 1'b0, 8'h80, 8'h7F));
		send_report(make_report(32'h0000_FFFE, 32'h0000_0002, 5'h15, 1'b0, 1'b0, 8'hFF, 8'h01));
	endtask

	// Absolute mapping: range ends, strays outside the range, hover gating, full 32-bit
	// range, then zero and reversed spans that hold the last position.
	task automatic test_absolute_mapping();
		write_register(CFG_RELATIVE_MODE, 32'd0);
		write_register(CFG_X_LOWER, 32'd0);
		write_register(CFG_X_UPPER, 32'd1000);
		write_register(CFG_Y_LOWER, 32'(-500));
		write_register(CFG_Y_UPPER, 32'd500);
		write_register(CFG_HAS_IN_RANGE, 32'd1);
		send_report(make_report(32'd0, 32'(-500), 5'h00, 1'b0, 1'b1, 8'h00, 8'h00));
		send_report(make_report(32'd1000, 32'd500, 5'h01, 1'b0, 1'b0, 8'h01, 8'h01));
		send_report(make_report(32'(-5), 32'd600, 5'h10, 1'b1, 1'b1, 8'hFE, 8'h02));
		send_report(make_report(32'd500, 32'd0, 5'h08, 1'b0, 1'b1, 8'h00, 8'h00));
		write_register(CFG_HAS_IN_RANGE, 32'd0);
		write_register(CFG_X_LOWER, 32'h8000_0000);
		write_register(CFG_X_UPPER, 32'h7FFF_FFFF);
		write_register(CFG_Y_UPPER, 32'(-500));
		send_report(make_report(32'h8000_0000, 32'd7, 5'h03, 1'b0, 1'b1, 8'h00, 8'h00));
		send_report(make_report(32'h7FFF_FFFF, 32'd9, 5'h00, 1'b1, 1'b1, 8'h00, 8'h00));
		write_register(CFG_Y_LOWER, 32'd100);
		send_report(make_report(32'h0000_0000, 32'h8000_0000, 5'h1C, 1'b0, 1'b0, 8'h33, 8'hCC));
	endtask

	// Oversized canvas (window clamping and every window boundary), resync saturation on a
	// one-pixel-wide canvas, and zero sizes treated as one.
	task automatic test_canvas_extremes();
		write_register(CFG_CANVAS_WIDTH, 32'd1023);
		write_register(CFG_CANVAS_HEIGHT, 32'd511);
		write_register(CFG_X_LOWER, 32'd0);
		write_register(CFG_X_UPPER, 32'd1022);
		write_register(CFG_Y_LOWER, 32'd0);
		write_register(CFG_Y_UPPER, 32'd510);
		send_report(make_report(32'd1022, 32'd510, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		send_report(make_report(32'd764, 32'd509, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		send_report(make_report(32'd254, 32'd254, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		send_report(make_report(32'd255, 32'd255, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		send_report(make_report(32'd509, 32'd0, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		send_report(make_report(32'd510, 32'd1, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		// tall canvas, width one: the resynced Y reference saturates
		write_register(CFG_CANVAS_WIDTH, 32'd1);
		send_report(make_report(32'd0, 32'd510, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		// back to relative: the saturated reference clamps on the next move
		write_register(CFG_RELATIVE_MODE, 32'd1);
		send_report(make_report(32'd0, 32'd0, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		write_register(CFG_CANVAS_WIDTH, 32'd0);
		write_register(CFG_CANVAS_HEIGHT, 32'd0);
		send_report(make_report(32'd3, 32'd3, 5'h00, 1'b0, 1'b0, 8'h00, 8'h00));
		write_register(CFG_RELATIVE_MODE, 32'd0);
		send_report(make_report(32'd5, 32'd5, 5'h00, 1'b0, 1'b1, 8'h00, 8'h00));
	endtask

	task automatic test_random_traffic();
		run_phases(11, 150);
	endtask

	// Last stretch with both sides always ready
	task automatic test_back_to_back();
		no_stall = 1'b1;
		run_phases(2, 100);
	endtask

	// Receiver: hold m_tready low in random bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (!no_stall && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else
			m_tready <= 1'b1;
	end

	// Compare every result transfer, field by field, with the oldest prediction
	always @(posedge clk) begin
		pointer_result_t got;
		pointer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				for (int i = 0; i < 8; i++) begin
					if (got[8*i +: 8] !== want[8*i +: 8]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch on %s: expected %0d, got %0d",
								result_field_names[i], want[8*i +: 8], got[8*i +: 8]);
					end
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_relative_reset_state();
		test_absolute_mapping();
		test_canvas_extremes();
		test_random_traffic();
		test_back_to_back();
		// drain, then watch a while for stray results
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/ppt_pkg.sv
src/ppt_div.sv
src/ppt_seq.sv
src/pointer_position_tracker.sv
sim/pointer_position_tracker_tb.sv
